// ----- rtl/sha1_stream_hash_defines.svh -----
// Assertion macros used by the top module of the SHA-1 stream hash RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SHA1_STREAM_HASH_DEFINES_SVH
`define SHA1_STREAM_HASH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1SH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 stream hash assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SHA1SH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 stream hash assertion failed");

`endif

// ----- rtl/sha1sh_pkg.sv -----
// Shared types, constants and round functions for the SHA-1 stream hash.
// No dependencies; imported by every module of the block.
package sha1sh_pkg;

    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = 16;
    localparam int NUM_ROUNDS  = 80;
    localparam int HASH_WORDS  = 5;
    localparam int POS_W       = 4;
    localparam int ROUND_W     = 7;
    localparam int IDX_W       = 3;

    localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(NUM_WORDS - 1);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(HASH_WORDS - 1);

    localparam logic [WORD_W-1:0] HASH_IV [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    // Control from the sequencer to the round datapath.
    typedef struct packed {
        logic               load_iv;
        logic               init_work;
        logic               round_en;
        logic               add_en;
        logic [ROUND_W-1:0] round_idx;
    } ctrl_t;

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] k;
        if (t < ROUND_W'(20))
            k = 32'h5A827999;
        else if (t < ROUND_W'(40))
            k = 32'h6ED9EBA1;
        else if (t < ROUND_W'(60))
            k = 32'h8F1BBCDC;
        else
            k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(
        input logic [ROUND_W-1:0] t,
        input logic [WORD_W-1:0]  b,
        input logic [WORD_W-1:0]  c,
        input logic [WORD_W-1:0]  d
    );
        logic [WORD_W-1:0] f;
        if (t < ROUND_W'(20))
            f = (b & c) | (~b & d);
        else if (t < ROUND_W'(40))
            f = b ^ c ^ d;
        else if (t < ROUND_W'(60))
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

// ----- rtl/sha1_stream_hash.sv -----
// Words 1 to 15 of a block are taken one per cycle while word_valid is high. The 16th
// word starts 80 rounds on the single round unit and one chaining add; the block takes
// no new word until they are done. A final block then shows five digest transfers,
// one per cycle when digest_ready is high, before the next word is taken.
// Reset loads the SHA-1 initial values into the chaining value and clears the word
// position; the block is ready as soon as reset is released.
`include "sha1_stream_hash_defines.svh"
module sha1_stream_hash
    import sha1sh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              word_valid,
    output logic              word_ready,
    input  logic [WORD_W-1:0] message_word,
    input  logic              start_of_message,
    input  logic              final_block,
    output logic              digest_valid,
    input  logic              digest_ready,
    output logic [WORD_W-1:0] digest_word,
    output logic [IDX_W-1:0]  digest_index,
    output logic              last_of_digest
);

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               final_reg, final_next;

    ctrl_t             ctrl;
    logic              word_fire;
    logic              digest_fire;
    logic              last_word;
    logic [WORD_W-1:0] w_cur;
    logic [WORD_W-1:0] chain [HASH_WORDS];

    assign word_fire   = word_valid && word_ready;
    assign digest_fire = digest_valid && digest_ready;
    assign last_word   = (pos_reg == LAST_POS);

    sha1sh_sched u_sched (
        .clk       (clk),
        .load_en   (word_fire),
        .load_word (message_word),
        .round_en  (ctrl.round_en),
        .w_cur     (w_cur)
    );

    sha1sh_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .w_cur (w_cur),
        .chain (chain)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (word_fire && last_word)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = final_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (digest_fire && idx_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and counters. In the idle state the input is always ready, so a
    // valid word there is a transfer.
    always_comb
    begin
        word_ready     = 1'b0;
        digest_valid   = 1'b0;
        ctrl.load_iv   = 1'b0;
        ctrl.init_work = 1'b0;
        ctrl.round_en  = 1'b0;
        ctrl.add_en    = 1'b0;
        ctrl.round_idx = round_reg;
        pos_next       = pos_reg;
        round_next     = '0;
        idx_next       = '0;
        final_next     = final_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                word_ready     = 1'b1;
                ctrl.load_iv   = word_valid && start_of_message;
                ctrl.init_work = word_valid && last_word;
                if (word_valid)
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (last_word)
                        final_next = final_block;
                end
            end
            ST_ROUND:
            begin
                ctrl.round_en = 1'b1;
                round_next    = round_reg + ROUND_W'(1);
            end
            ST_ADD:
            begin
                ctrl.add_en = 1'b1;
            end
            ST_EMIT:
            begin
                digest_valid = 1'b1;
                if (!digest_fire)
                    idx_next = idx_reg;
                else if (idx_reg != LAST_IDX)
                    idx_next = idx_reg + IDX_W'(1);
            end
            default:
            begin
                word_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            final_reg <= final_next;
        end
    end

    assign digest_word    = chain[idx_reg];
    assign digest_index   = idx_reg;
    assign last_of_digest = (idx_reg == LAST_IDX);

    `SHA1SH_ASSERT_NOW(a_no_overlap, word_ready, !digest_valid)
    `SHA1SH_ASSERT_NOW(a_index_range, digest_valid, idx_reg <= LAST_IDX)
    `SHA1SH_ASSERT_NEXT(a_block_starts, word_fire && last_word, state_reg == ST_ROUND && round_reg == '0)
    `SHA1SH_ASSERT_NEXT(a_rounds_end, state_reg == ST_ROUND && round_reg == LAST_ROUND, state_reg == ST_ADD)
    `SHA1SH_ASSERT_NEXT(a_digest_done, digest_fire && last_of_digest, word_ready && pos_reg == '0)

endmodule

// ----- rtl/sha1sh_sched.sv -----
// Sixteen-word message schedule window for the SHA-1 stream hash.
// Depends on sha1sh_pkg; words shift in on input transfers and expand during rounds.
module sha1sh_sched
    import sha1sh_pkg::*;
(
    input  logic              clk,
    input  logic              load_en,
    input  logic [WORD_W-1:0] load_word,
    input  logic              round_en,
    output logic [WORD_W-1:0] w_cur
);

    logic [WORD_W-1:0] win_reg  [NUM_WORDS];
    logic [WORD_W-1:0] win_next [NUM_WORDS];
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] expanded;

    // Entry 0 always holds W[t]; the word sixteen rounds ahead is appended at the end.
    assign w_cur    = win_reg[0];
    assign mix      = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign expanded = {mix[WORD_W-2:0], mix[WORD_W-1]};

    always_comb
    begin
        for (int i = 0; i < NUM_WORDS - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[NUM_WORDS - 1] = load_en ? load_word : expanded;
    end

    always_ff @(posedge clk)
    begin
        if (load_en || round_en)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

// ----- rtl/sha1sh_core.sv -----
// Working variables, shared round unit and chaining value of the SHA-1 stream hash.
// Depends on sha1sh_pkg; driven by the sequencer in sha1_stream_hash.
module sha1sh_core
    import sha1sh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_t             ctrl,
    input  logic [WORD_W-1:0] w_cur,
    output logic [WORD_W-1:0] chain [HASH_WORDS]
);

    logic [WORD_W-1:0] cv_reg   [HASH_WORDS];
    logic [WORD_W-1:0] work_reg [HASH_WORDS];
    logic [WORD_W-1:0] temp;
    logic [WORD_W-1:0] a_rot;

    assign chain = cv_reg;

    assign a_rot = {work_reg[0][WORD_W-6:0], work_reg[0][WORD_W-1:WORD_W-5]};
    assign temp  = a_rot + round_f(ctrl.round_idx, work_reg[1], work_reg[2], work_reg[3])
                 + work_reg[4] + w_cur + round_k(ctrl.round_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= HASH_IV;
        end
        else if (ctrl.load_iv)
        begin
            cv_reg <= HASH_IV;
        end
        else if (ctrl.add_en)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                cv_reg[i] <= cv_reg[i] + work_reg[i];
            end
        end
    end

    // A start flag on the block's last word seeds the rounds with the initial values.
    always_ff @(posedge clk)
    begin
        if (ctrl.init_work)
        begin
            if (ctrl.load_iv)
            begin
                work_reg <= HASH_IV;
            end
            else
            begin
                work_reg <= cv_reg;
            end
        end
        else if (ctrl.round_en)
        begin
            work_reg[0] <= temp;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][WORD_W-1:2]};
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
    end

endmodule

// ----- tb/sha1_digest_checker.sv -----
// Checker for the SHA-1 stream hash: watches both channels, predicts the digest words.
// Depends on sha1sh_pkg for widths and the initial hash values.
`timescale 1ns / 100ps

module sha1_digest_checker
    import sha1sh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              word_valid,
    input  logic              word_ready,
    input  logic [WORD_W-1:0] message_word,
    input  logic              start_of_message,
    input  logic              final_block,
    input  logic              digest_valid,
    input  logic              digest_ready,
    input  logic [WORD_W-1:0] digest_word,
    input  logic [IDX_W-1:0]  digest_index,
    input  logic              last_of_digest,
    output int                mismatch_count,
    output int                digests_pending
);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  index;
        logic              last;
    } digest_beat_t;

    localparam logic [WORD_W-1:0] ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    logic [WORD_W-1:0] chain_value [HASH_WORDS];
    logic [WORD_W-1:0] block_buf [NUM_WORDS];
    logic [POS_W-1:0]  block_pos;
    digest_beat_t      expected_digest_q [$];
    int                errors;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // One full SHA-1 compression of block_buf folded into chain_value.
    function automatic void compress_block();
        logic [WORD_W-1:0] sched [NUM_ROUNDS];
        logic [WORD_W-1:0] a, b, c, d, e, f, sum;
        for (int t = 0; t < NUM_WORDS; t++)
            sched[t] = block_buf[t];
        for (int t = NUM_WORDS; t < NUM_ROUNDS; t++)
            sched[t] = rotl(sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16], 1);
        a = chain_value[0];
        b = chain_value[1];
        c = chain_value[2];
        d = chain_value[3];
        e = chain_value[4];
        for (int t = 0; t < NUM_ROUNDS; t++)
        begin
            if (t < 20)
                f = (b & c) | (~b & d);
            else if (t < 40)
                f = b ^ c ^ d;
            else if (t < 60)
                f = (b & c) | (b & d) | (c & d);
            else
                f = b ^ c ^ d;
            sum = rotl(a, 5) + f + e + sched[t] + ROUND_K[t / 20];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        chain_value[0] = chain_value[0] + a;
        chain_value[1] = chain_value[1] + b;
        chain_value[2] = chain_value[2] + c;
        chain_value[3] = chain_value[3] + d;
        chain_value[4] = chain_value[4] + e;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] exp_val,
                                 input logic [WORD_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %08h, actual %08h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
                chain_value[i] = HASH_IV[i];
            block_pos = '0;
            expected_digest_q.delete();
            errors = 0;
            mismatch_count <= 0;
            digests_pending <= 0;
        end
        else
        begin
            if (digest_valid && digest_ready)
            begin
                if (expected_digest_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected digest transfer, expected none, actual %08h",
                             $time, digest_word);
                end
                else
                begin
                    digest_beat_t exp_beat;
                    exp_beat = expected_digest_q.pop_front();
                    compare_field("digest_word", exp_beat.word, digest_word);
                    compare_field("digest_index", WORD_W'(exp_beat.index),
                                  WORD_W'(digest_index));
                    compare_field("last_of_digest", WORD_W'(exp_beat.last),
                                  WORD_W'(last_of_digest));
                end
            end

            if (word_valid && word_ready)
            begin
                // A start only reloads the chaining value; block alignment is kept.
                if (start_of_message)
                    for (int i = 0; i < HASH_WORDS; i++)
                        chain_value[i] = HASH_IV[i];
                block_buf[block_pos] = message_word;
                if (block_pos == LAST_POS)
                begin
                    block_pos = '0;
                    compress_block();
                    if (final_block)
                        for (int i = 0; i < HASH_WORDS; i++)
                            expected_digest_q.push_back('{chain_value[i], IDX_W'(i),
                                                           i == HASH_WORDS - 1});
                end
                else
                    block_pos = block_pos + 1'b1;
            end

            mismatch_count <= errors;
            digests_pending <= expected_digest_q.size();
        end
    end

endmodule

// ----- tb/sha1_stream_hash_test.sv -----
// Top of the SHA-1 stream hash testbench: clock, reset, word stimulus and digest back-pressure.
// Depends on sha1sh_pkg, the sha1_stream_hash RTL and sha1_digest_checker.
`timescale 1ns / 100ps

module sha1_stream_hash_test;
    import sha1sh_pkg::*;

    localparam int RANDOM_WORDS  = 200;
    localparam int MIN_DIGESTS   = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 120;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [WORD_W-1:0] DIRECTED_WORDS [NUM_WORDS] = '{
        32'h61626380, 32'hFFFFFFFF, 32'h00000000, 32'h80000000,
        32'h00000001, 32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF,
        32'hFFFFFFFE, 32'h00000000, 32'hFFFFFFFF, 32'h55555555,
        32'hAAAAAAAA, 32'h00000000, 32'h00000000, 32'h00000018
    };

    logic              clk;
    logic              rst_n;
    logic              word_valid;
    logic              word_ready;
    logic [WORD_W-1:0] message_word;
    logic              start_of_message;
    logic              final_block;
    logic              digest_valid;
    logic              digest_ready;
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0]  digest_index;
    logic              last_of_digest;

    int mismatch_count;
    int digests_pending;
    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int digests_due;
    int stream_pos;
    int cycle_count;
    int hold_cycles;
    bit pressure_armed;
    bit pressure_used;

    sha1_stream_hash i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .word_valid       (word_valid),
        .word_ready       (word_ready),
        .message_word     (message_word),
        .start_of_message (start_of_message),
        .final_block      (final_block),
        .digest_valid     (digest_valid),
        .digest_ready     (digest_ready),
        .digest_word      (digest_word),
        .digest_index     (digest_index),
        .last_of_digest   (last_of_digest)
    );

    sha1_digest_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .word_valid       (word_valid),
        .word_ready       (word_ready),
        .message_word     (message_word),
        .start_of_message (start_of_message),
        .final_block      (final_block),
        .digest_valid     (digest_valid),
        .digest_ready     (digest_ready),
        .digest_word      (digest_word),
        .digest_index     (digest_index),
        .last_of_digest   (last_of_digest),
        .mismatch_count   (mismatch_count),
        .digests_pending  (digests_pending)
    );

    initial
        clk = 1'b0;

    always
        #5 clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Phases 0 and 4 run without any idling.
    task automatic set_phase(input int phase);
        case (phase)
            1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
            3:       begin send_idle_pct = 12; recv_stall_pct = 12; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic som, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid       <= 1'b1;
        message_word     <= w;
        start_of_message <= som;
        final_block      <= fin;
        do
            @(posedge clk);
        while (!word_ready);
        if (stream_pos == NUM_WORDS - 1 && fin)
            digests_due++;
        stream_pos = (stream_pos + 1) % NUM_WORDS;
        words_sent++;
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Digest side: random stalls, plus one long hold-off that backs the block up.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pressure_armed && !pressure_used && digest_valid)
            begin
                pressure_used = 1'b1;
                digest_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++)
                    @(posedge clk);
            end
            else
                digest_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int msg;
        int blocks;
        int stray;
        bit som;
        bit fin;
        rst_n            <= 1'b0;
        word_valid       <= 1'b0;
        message_word     <= '0;
        start_of_message <= 1'b0;
        final_block      <= 1'b0;
        digest_ready     <= 1'b0;
        set_phase(0);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed block: field extremes, a start in the middle of the block and an
        // early final flag that must be ignored.
        for (int i = 0; i < NUM_WORDS; i++)
            send_word(DIRECTED_WORDS[i], i == 0 || i == 7, i == 9 || i == NUM_WORDS - 1);

        msg = 0;
        while (words_sent < NUM_WORDS + RANDOM_WORDS || digests_due < MIN_DIGESTS)
        begin
            set_phase(msg % 5);
            if (msg == 4)
                pressure_armed = 1'b1;
            // Now and then a few stray words shift the block boundary of the next message.
            if ($urandom_range(0, 9) == 0)
            begin
                stray = $urandom_range(1, NUM_WORDS - 1);
                for (int i = 0; i < stray; i++)
                    send_word(random_word(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
            blocks = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
            for (int b = 0; b < blocks; b++)
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    if (b == 0 && i == 0)
                        som = ($urandom_range(0, 9) != 0);
                    else
                        som = ($urandom_range(0, 29) == 0);
                    if (i == NUM_WORDS - 1)
                        fin = (b == blocks - 1) && ($urandom_range(0, 7) != 0);
                    else
                        fin = ($urandom_range(0, 3) == 0);
                    send_word(random_word(), som, fin);
                end
            msg++;
        end
        word_valid <= 1'b0;

        set_phase(0);
        @(posedge clk);
        while (digests_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sha1sh_pkg.sv
rtl/sha1sh_sched.sv
rtl/sha1sh_core.sv
rtl/sha1_stream_hash.sv
tb/sha1_digest_checker.sv
tb/sha1_stream_hash_test.sv
